// File: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and sizes for the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int PageW     = 12;   // page number width (page shift)
  localparam int OrderW    = 4;
  localparam int OpW       = 2;
  localparam int StatW     = 2;
  localparam int CfgW      = 13;
  localparam int TagW      = 5;    // order + 1, zero when no block starts here
  localparam int FmW       = 64;   // free map row width
  localparam int DefPages  = 4096;
  localparam int DefOrders = 11;
  localparam int PoolReset = 4096;

  localparam logic [OpW-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OpW-1:0] OP_FREE    = 2'd1;
  localparam logic [OpW-1:0] OP_REBUILD = 2'd2;

  localparam logic [StatW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatW-1:0] ST_NO_BLOCK  = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [StatW-1:0] ST_BAD_ORDER = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [OrderW-1:0] order;
    logic [PageW-1:0]  block_page;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [PageW-1:0]  page;
    logic [StatW-1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_PICK, DP_SCAN_RD, DP_SCAN_CHK, DP_SPLIT_RD, DP_SPLIT_WR,
    DP_TAG_WR, DP_TAG_RD, DP_TAG_CHK, DP_MRG_RD, DP_MRG_CHK, DP_PUT_RD,
    DP_PUT_WR, DP_RB_INIT, DP_RB_STEP
  } dp_cmd_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             ord_bad;
    logic             page_bad;
    logic             avail;
    logic             hit;
    logic             at_ord;
    logic             tag_zero;
    logic             can_merge;
    logic             buddy_free;
    logic             sweep_last;
    logic [PageW-1:0] page;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: src/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: free map rows, allocation tags, per-order free counts.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_dp #(
  parameter int PAGES  = bpa_pkg::DefPages,
  parameter int ORDERS = bpa_pkg::DefOrders
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bpa_pkg::dp_cmd_t          cmd,
  input  wire bpa_pkg::in_item_t         in_data,
  input  wire logic                      cfg_we,
  input  wire logic [bpa_pkg::CfgW-1:0]  cfg_data,
  output bpa_pkg::dp_stat_t              stat
);

  localparam int AW  = $clog2(PAGES);
  localparam int CW  = AW + 1;
  localparam int LW  = $clog2(bpa_pkg::FmW);
  localparam int LVW = (ORDERS > 1) ? $clog2(ORDERS) : 1;

  function automatic int rows_f(int k);
    int n;
    n = ((PAGES >> k) + bpa_pkg::FmW - 1) >> LW;
    return (n > 0) ? n : 1;
  endfunction

  function automatic int base_f(int k);
    int s;
    s = 0;
    for (int i = 0; i < k; i++) s += rows_f(i);
    return s;
  endfunction

  localparam int ROWS  = base_f(ORDERS);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SWEEP = (ROWS > PAGES) ? ROWS : PAGES;
  localparam int SW    = $clog2(SWEEP);

  logic [RW-1:0] base_w  [ORDERS];
  logic [RW-1:0] rlast_w [ORDERS];
  logic [CW-1:0] len_w   [ORDERS];

  for (genvar g = 0; g < ORDERS; g++) begin : g_lvl
    assign base_w[g]  = RW'(base_f(g));
    assign rlast_w[g] = RW'(rows_f(g) - 1);
    assign len_w[g]   = CW'(PAGES >> g);
  end

  logic [bpa_pkg::FmW-1:0]  fm [ROWS];
  logic [bpa_pkg::TagW-1:0] tag [PAGES];

  logic [bpa_pkg::OpW-1:0]  op_r;
  logic                     ord_bad_r, page_bad_r;
  logic [LVW-1:0]           ord_r, lvl_r;
  logic [AW-1:0]            addr_r;
  logic [RW-1:0]            scan_r, rd_row_r;
  logic [LW-1:0]            bit_r;
  logic                     inrange_r;
  logic [bpa_pkg::FmW-1:0]  rdata_r;
  logic [bpa_pkg::TagW-1:0] tag_q_r;
  logic [CW-1:0]            cnt_r [ORDERS];
  logic [bpa_pkg::CfgW-1:0] pool_r;
  logic [CW-1:0]            cpool_r;
  logic [SW-1:0]            sweep_r;
  logic [LVW-1:0]           rb_lvl_r;
  logic [RW-1:0]            rb_row_r;

  // read address for block-addressed accesses
  logic [LVW-1:0] rd_lvl;
  logic [31:0]    rd_idx;
  logic [RW-1:0]  raddr;
  logic           fm_re;

  always_comb begin
    rd_lvl = lvl_r;
    rd_idx = 32'(addr_r) >> lvl_r;
    case (cmd)
      bpa_pkg::DP_SPLIT_RD: begin
        rd_lvl = LVW'(lvl_r - 1'b1);
        rd_idx = (32'(addr_r) >> rd_lvl) | 32'd1;
      end
      bpa_pkg::DP_MRG_RD: rd_idx = (32'(addr_r) >> lvl_r) ^ 32'd1;
      default: ;
    endcase
    if (cmd == bpa_pkg::DP_SCAN_RD) raddr = base_w[lvl_r] + scan_r;
    else raddr = base_w[rd_lvl] + RW'(rd_idx >> LW);
    fm_re = (cmd == bpa_pkg::DP_SCAN_RD) || (cmd == bpa_pkg::DP_SPLIT_RD) ||
            (cmd == bpa_pkg::DP_MRG_RD) || (cmd == bpa_pkg::DP_PUT_RD);
  end

  // lowest free block in the row just read
  logic [LW-1:0] pe;
  always_comb begin
    pe = '0;
    for (int b = bpa_pkg::FmW - 1; b >= 0; b--) if (rdata_r[b]) pe = LW'(b);
  end

  logic hit, buddy_free, rb_on;
  assign hit        = |rdata_r;
  assign buddy_free = rdata_r[bit_r] && inrange_r;
  assign rb_on      = 32'(sweep_r) < ROWS;

  // lowest order at or above the request that has a free block
  logic           avail;
  logic [LVW-1:0] pick_lvl;
  always_comb begin
    avail    = 1'b0;
    pick_lvl = ord_r;
    for (int k = 0; k < ORDERS; k++) begin
      if (!avail && k >= 32'(ord_r) && cnt_r[k] != '0) begin
        avail    = 1'b1;
        pick_lvl = LVW'(k);
      end
    end
  end

  // rebuild row: top order holds the run of full blocks, each lower order
  // at most the one block left by the greedy split
  logic [bpa_pkg::FmW-1:0] rb_word;
  always_comb begin
    logic [31:0] idx, cp, tgt;
    cp  = 32'(cpool_r);
    tgt = (cp >> (32'(rb_lvl_r) + 1)) << 1;
    for (int b = 0; b < bpa_pkg::FmW; b++) begin
      idx = (32'(rb_row_r) << LW) + 32'(b);
      if (32'(rb_lvl_r) == ORDERS - 1) rb_word[b] = idx < (cp >> rb_lvl_r);
      else rb_word[b] = ((cp >> rb_lvl_r) & 32'd1) != 0 && idx == tgt;
    end
  end

  logic [CW-1:0] clamp;
  assign clamp = (32'(pool_r) > PAGES) ? CW'(PAGES) : CW'(pool_r);

  // free map write port
  logic                    fm_we;
  logic [RW-1:0]           fm_waddr;
  logic [bpa_pkg::FmW-1:0] fm_wdata;
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = rd_row_r;
    fm_wdata = rdata_r;
    case (cmd)
      bpa_pkg::DP_SCAN_CHK: begin
        fm_we    = hit;
        fm_wdata = rdata_r & ~(bpa_pkg::FmW'(1) << pe);
      end
      bpa_pkg::DP_SPLIT_WR, bpa_pkg::DP_PUT_WR: begin
        fm_we    = 1'b1;
        fm_wdata = rdata_r | (bpa_pkg::FmW'(1) << bit_r);
      end
      bpa_pkg::DP_MRG_CHK: begin
        fm_we    = buddy_free;
        fm_wdata = rdata_r & ~(bpa_pkg::FmW'(1) << bit_r);
      end
      bpa_pkg::DP_RB_STEP: begin
        fm_we    = rb_on;
        fm_waddr = sweep_r[RW-1:0];
        fm_wdata = rb_word;
      end
      default: ;
    endcase
  end

  // tag write port
  logic                     tag_we;
  logic [AW-1:0]            tag_waddr;
  logic [bpa_pkg::TagW-1:0] tag_wdata;
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = addr_r;
    tag_wdata = '0;
    case (cmd)
      bpa_pkg::DP_TAG_WR: begin
        tag_we    = 1'b1;
        tag_wdata = bpa_pkg::TagW'(ord_r) + 1'b1;
      end
      bpa_pkg::DP_TAG_CHK: tag_we = (tag_q_r != '0);
      bpa_pkg::DP_RB_STEP: begin
        tag_we    = 32'(sweep_r) < PAGES;
        tag_waddr = sweep_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm[fm_waddr] <= fm_wdata;
    if (fm_re) rdata_r <= fm[raddr];
    if (tag_we) tag[tag_waddr] <= tag_wdata;
    if (cmd == bpa_pkg::DP_TAG_RD) tag_q_r <= tag[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= bpa_pkg::CfgW'(bpa_pkg::PoolReset);
    end else if (cfg_we) begin
      pool_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (fm_re) begin
      rd_row_r  <= raddr;
      bit_r     <= rd_idx[LW-1:0];
      inrange_r <= rd_idx < 32'(len_w[rd_lvl]);
    end
    case (cmd)
      bpa_pkg::DP_LOAD: begin
        op_r       <= in_data.operation;
        ord_r      <= LVW'(in_data.order);
        ord_bad_r  <= 32'(in_data.order) >= ORDERS;
        page_bad_r <= 32'(in_data.block_page) >= PAGES;
        addr_r     <= AW'(in_data.block_page);
      end
      bpa_pkg::DP_PICK: begin
        lvl_r  <= pick_lvl;
        scan_r <= '0;
      end
      bpa_pkg::DP_SCAN_CHK: begin
        if (hit) begin
          addr_r        <= AW'(((32'(scan_r) << LW) | 32'(pe)) << lvl_r);
          cnt_r[lvl_r]  <= cnt_r[lvl_r] - 1'b1;
        end else begin
          scan_r <= scan_r + 1'b1;
        end
      end
      bpa_pkg::DP_SPLIT_WR: begin
        cnt_r[LVW'(lvl_r - 1'b1)] <= cnt_r[LVW'(lvl_r - 1'b1)] + 1'b1;
        lvl_r <= LVW'(lvl_r - 1'b1);
      end
      bpa_pkg::DP_TAG_CHK: lvl_r <= LVW'(tag_q_r - 1'b1);
      bpa_pkg::DP_MRG_CHK: begin
        if (buddy_free) begin
          cnt_r[lvl_r] <= cnt_r[lvl_r] - 1'b1;
          addr_r       <= addr_r & ~(AW'(1) << lvl_r);
          lvl_r        <= LVW'(lvl_r + 1'b1);
        end
      end
      bpa_pkg::DP_PUT_WR: cnt_r[lvl_r] <= cnt_r[lvl_r] + 1'b1;
      bpa_pkg::DP_RB_INIT: begin
        cpool_r  <= clamp;
        sweep_r  <= '0;
        rb_lvl_r <= '0;
        rb_row_r <= '0;
        for (int k = 0; k < ORDERS; k++) begin
          if (k == ORDERS - 1) cnt_r[k] <= CW'(32'(clamp) >> k);
          else cnt_r[k] <= CW'((32'(clamp) >> k) & 32'd1);
        end
      end
      bpa_pkg::DP_RB_STEP: begin
        sweep_r <= sweep_r + 1'b1;
        if (rb_row_r == rlast_w[rb_lvl_r]) begin
          rb_row_r <= '0;
          if (32'(rb_lvl_r) < ORDERS - 1) rb_lvl_r <= LVW'(rb_lvl_r + 1'b1);
        end else begin
          rb_row_r <= rb_row_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.op         = op_r;
    stat.ord_bad    = ord_bad_r;
    stat.page_bad   = page_bad_r;
    stat.avail      = avail;
    stat.hit        = hit;
    stat.at_ord     = (lvl_r == ord_r);
    stat.tag_zero   = (tag_q_r == '0);
    stat.can_merge  = 32'(lvl_r) < ORDERS - 1;
    stat.buddy_free = buddy_free;
    stat.sweep_last = 32'(sweep_r) == SWEEP - 1;
    stat.page       = bpa_pkg::PageW'(32'(addr_r));
  end

endmodule

`default_nettype wire

// File: src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller: sequences allocate, free and rebuild; holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bpa_pkg::out_item_t       out_data,
  output bpa_pkg::dp_cmd_t         dp_cmd,
  input  wire bpa_pkg::dp_stat_t   dp_stat
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DISPATCH  = 16'h0002,
    S_PICK      = 16'h0004,
    S_SCAN_RD   = 16'h0008,
    S_SCAN_CHK  = 16'h0010,
    S_SPLIT_RD  = 16'h0020,
    S_SPLIT_WR  = 16'h0040,
    S_TAG_WR    = 16'h0080,
    S_TAG_RD    = 16'h0100,
    S_TAG_CHK   = 16'h0200,
    S_MRG_RD    = 16'h0400,
    S_MRG_CHK   = 16'h0800,
    S_PUT_RD    = 16'h1000,
    S_PUT_WR    = 16'h2000,
    S_RB_STEP   = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        boot_r, boot_nxt;
  logic                        res_ok_r, res_ok_nxt;
  logic [bpa_pkg::StatW-1:0]   res_st_r, res_st_nxt;
  logic                        out_valid_r;
  bpa_pkg::out_item_t          out_data_r;
  logic                        fire;
  logic                        rb_init;

  always_comb begin
    state_nxt  = state_r;
    boot_nxt   = boot_r;
    res_ok_nxt = res_ok_r;
    res_st_nxt = res_st_r;
    dp_cmd     = bpa_pkg::DP_NOP;
    fire       = 1'b0;
    rb_init    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd    = bpa_pkg::DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_ok_nxt = 1'b0;
        state_nxt  = S_DONE;
        case (dp_stat.op)
          bpa_pkg::OP_ALLOC: begin
            res_st_nxt = bpa_pkg::ST_BAD_ORDER;
            if (!dp_stat.ord_bad) state_nxt = S_PICK;
          end
          bpa_pkg::OP_FREE: begin
            res_st_nxt = bpa_pkg::ST_NOT_ALLOC;
            if (!dp_stat.page_bad) state_nxt = S_TAG_RD;
          end
          bpa_pkg::OP_REBUILD: rb_init = 1'b1;
          default: res_st_nxt = bpa_pkg::ST_BAD_ORDER;
        endcase
      end
      S_PICK: begin
        dp_cmd = bpa_pkg::DP_PICK;
        if (dp_stat.avail) begin
          state_nxt = S_SCAN_RD;
        end else begin
          res_st_nxt = bpa_pkg::ST_NO_BLOCK;
          state_nxt  = S_DONE;
        end
      end
      S_SCAN_RD: begin
        dp_cmd    = bpa_pkg::DP_SCAN_RD;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        dp_cmd    = bpa_pkg::DP_SCAN_CHK;
        state_nxt = dp_stat.hit ? S_SPLIT_RD : S_SCAN_RD;
      end
      S_SPLIT_RD: begin
        if (dp_stat.at_ord) begin
          state_nxt = S_TAG_WR;
        end else begin
          dp_cmd    = bpa_pkg::DP_SPLIT_RD;
          state_nxt = S_SPLIT_WR;
        end
      end
      S_SPLIT_WR: begin
        dp_cmd    = bpa_pkg::DP_SPLIT_WR;
        state_nxt = S_SPLIT_RD;
      end
      S_TAG_WR: begin
        dp_cmd     = bpa_pkg::DP_TAG_WR;
        res_ok_nxt = 1'b1;
        res_st_nxt = bpa_pkg::ST_DONE;
        state_nxt  = S_DONE;
      end
      S_TAG_RD: begin
        dp_cmd    = bpa_pkg::DP_TAG_RD;
        state_nxt = S_TAG_CHK;
      end
      S_TAG_CHK: begin
        dp_cmd    = bpa_pkg::DP_TAG_CHK;
        state_nxt = dp_stat.tag_zero ? S_DONE : S_MRG_RD;
      end
      S_MRG_RD: begin
        if (dp_stat.can_merge) begin
          dp_cmd    = bpa_pkg::DP_MRG_RD;
          state_nxt = S_MRG_CHK;
        end else begin
          state_nxt = S_PUT_RD;
        end
      end
      S_MRG_CHK: begin
        dp_cmd    = bpa_pkg::DP_MRG_CHK;
        state_nxt = dp_stat.buddy_free ? S_MRG_RD : S_PUT_RD;
      end
      S_PUT_RD: begin
        dp_cmd    = bpa_pkg::DP_PUT_RD;
        state_nxt = S_PUT_WR;
      end
      S_PUT_WR: begin
        dp_cmd     = bpa_pkg::DP_PUT_WR;
        res_ok_nxt = 1'b1;
        res_st_nxt = bpa_pkg::ST_DONE;
        state_nxt  = S_DONE;
      end
      S_RB_STEP: begin
        dp_cmd = bpa_pkg::DP_RB_STEP;
        if (dp_stat.sweep_last) begin
          res_ok_nxt = 1'b1;
          res_st_nxt = bpa_pkg::ST_DONE;
          boot_nxt   = 1'b0;
          state_nxt  = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // rebuild entry is shared by reset and by the rebuild operation
    if (rb_init || (boot_r && state_r != S_RB_STEP)) begin
      dp_cmd    = bpa_pkg::DP_RB_INIT;
      state_nxt = S_RB_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      boot_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_ok_r <= res_ok_nxt;
    res_st_r <= res_st_nxt;
    if (fire) begin
      out_data_r.ok     <= res_ok_r;
      out_data_r.status <= res_st_r;
      out_data_r.page   <= (res_ok_r && dp_stat.op == bpa_pkg::OP_ALLOC) ?
                           dp_stat.page : '0;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || boot_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over a page pool: allocate, free with merge, rebuild.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall   in_item_t (operation, order, block_page)
//   out_     out  out_valid/out_stall out_item_t (ok, page, status)
//   cfg_     in   cfg_valid/cfg_ready pool_pages (13 bits)
//
// One item at a time. Allocate scans the 64-block rows at the chosen order and
// then splits level by level down to the order asked for; a bad order or no free
// block ends it early. Free merges level by level, up to the top order at most;
// an unknown page ends it early. Rebuild sweeps the free map and tag memories;
// the same sweep runs after reset with in_stall high. A finished result waits
// until the output register is free; the next beat is taken once it moves there.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator #(
  parameter int PAGES  = bpa_pkg::DefPages,
  parameter int ORDERS = bpa_pkg::DefOrders
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire bpa_pkg::in_item_t        in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output bpa_pkg::out_item_t            out_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [bpa_pkg::CfgW-1:0] cfg_data
);

  bpa_pkg::dp_cmd_t  dp_cmd;
  bpa_pkg::dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  bpa_dp #(
    .PAGES  (PAGES),
    .ORDERS (ORDERS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dp_cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (dp_stat)
  );

`ifndef ASSERT_OFF
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> dp_cmd == bpa_pkg::DP_LOAD)
    else $error("accepted beat not loaded into datapath");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != bpa_pkg::ST_DONE) |->
      (!out_data.ok && out_data.page == '0))
    else $error("failed result carries ok or page");

  a_boot_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during reset rebuild");
`endif

endmodule

`default_nettype wire
